// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define WHC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition is never true outside reset.
`define WHC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/whc_pkg.sv =====
// ----------------------------------------------------------------------------
// whc_pkg
// Constants, header byte table and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package whc_pkg;

    // Header length in bytes.
    localparam int HEADER_BYTES = 44;

    // Quotient bits produced by the serial divider (clock fits 28 bits).
    localparam int DIV_STEPS = 28;
    localparam int CLK_HZ_W  = 28;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration register indexes.
    localparam logic CFG_CLOCK_HZ = 1'b0;
    localparam logic CFG_PRESCALE = 1'b1;
    localparam int   CFG_DATA_W   = 28;

    // Prescaler code that divides by 256.
    localparam logic [2:0] PRESCALE_256 = 3'd7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic start;    // load the divider
        logic step;     // one quotient bit
        logic load;     // capture the result into the output register
    } whc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_byte;  // the offered beat is the final header byte
    } whc_status_t;

    // Expected byte at a header position: {checked, value}.
    function automatic logic [8:0] expect_byte(logic [5:0] pos);
        logic [8:0] e;
        unique case (pos)
            6'd0:    e = {1'b1, 8'h52};  // R
            6'd1:    e = {1'b1, 8'h49};  // I
            6'd2:    e = {1'b1, 8'h46};  // F
            6'd3:    e = {1'b1, 8'h46};  // F
            6'd8:    e = {1'b1, 8'h57};  // W
            6'd9:    e = {1'b1, 8'h41};  // A
            6'd10:   e = {1'b1, 8'h56};  // V
            6'd11:   e = {1'b1, 8'h45};  // E
            6'd12:   e = {1'b1, 8'h66};  // f
            6'd13:   e = {1'b1, 8'h6d};  // m
            6'd14:   e = {1'b1, 8'h74};  // t
            6'd15:   e = {1'b1, 8'h20};  // space
            6'd16:   e = {1'b1, 8'd16};  // format length
            6'd17:   e = {1'b1, 8'd0};
            6'd18:   e = {1'b1, 8'd0};
            6'd19:   e = {1'b1, 8'd0};
            6'd20:   e = {1'b1, 8'd1};   // PCM
            6'd21:   e = {1'b1, 8'd0};
            6'd22:   e = {1'b1, 8'd1};   // mono
            6'd23:   e = {1'b1, 8'd0};
            6'd32:   e = {1'b1, 8'd2};   // block align
            6'd33:   e = {1'b1, 8'd0};
            6'd34:   e = {1'b1, 8'd16};  // bits per sample
            6'd35:   e = {1'b1, 8'd0};
            6'd36:   e = {1'b1, 8'h64};  // d
            6'd37:   e = {1'b1, 8'h61};  // a
            6'd38:   e = {1'b1, 8'h74};  // t
            6'd39:   e = {1'b1, 8'h61};  // a
            default: e = {1'b0, 8'h00};  // skipped field or beyond header
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/whc_if.sv =====
// ----------------------------------------------------------------------------
// whc_if
// Valid/ready channels for header bytes in and parse results out.
// ----------------------------------------------------------------------------
interface whc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface whc_out_if;
    logic        valid;
    logic        ready;
    logic        header_ok;
    logic [31:0] timer_period;
    logic        rate_zero;

    modport source (output valid, output header_ok, output timer_period,
                    output rate_zero, input ready);
    modport sink   (input valid, input header_ok, input timer_period,
                    input rate_zero, output ready);
endinterface

// ===== rtl/whc_datapath.sv =====
// ----------------------------------------------------------------------------
// whc_datapath
// Header position, match flag, sample rate gather, serial divider and
// result register.
// ----------------------------------------------------------------------------
module whc_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  whc_pkg::whc_cmd_t              cmd,
    output whc_pkg::whc_status_t           status,
    input  logic [7:0]                     data_byte,
    input  logic                           first_byte,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [whc_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           header_ok,
    output logic [31:0]                    timer_period,
    output logic                           rate_zero
);

    localparam int QW = whc_pkg::CLK_HZ_W;

    logic [5:0]    pos_reg, pos_next;
    logic          match_reg, match_next;
    logic [31:0]   acc_reg, acc_next;
    logic [QW-1:0] clk_hz_reg;
    logic [2:0]    presc_reg;

    logic [31:0]   rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic          ok_out_reg;
    logic [31:0]   period_out_reg;
    logic          zero_out_reg;

    logic [5:0]    pos_eff;
    logic          match_eff;
    logic [31:0]   acc_eff;
    logic          active;
    logic [8:0]    exp_byte;
    logic [QW-1:0] scaled;
    logic [32:0]   rem_shift;
    logic          fits;
    logic          acc_zero;

    // Restart on the first byte of a file and flag the final header byte
    always_comb
    begin
        pos_eff   = first_byte ? 6'd0 : pos_reg;
        match_eff = first_byte ? 1'b1 : match_reg;
        acc_eff   = first_byte ? 32'd0 : acc_reg;
        active    = (pos_eff < 6'(whc_pkg::HEADER_BYTES));
        exp_byte  = whc_pkg::expect_byte(pos_eff);

        status.last_byte = active && (pos_eff == 6'(whc_pkg::HEADER_BYTES - 1));
    end

    // Check and gather on each accepted header beat
    always_comb
    begin
        pos_next   = pos_reg;
        match_next = match_reg;
        acc_next   = acc_reg;
        if (cmd.accept && active)
        begin
            pos_next   = pos_eff + 6'd1;
            match_next = match_eff && !(exp_byte[8] && (exp_byte[7:0] != data_byte));
            acc_next   = acc_eff;
            if (pos_eff >= 6'd24 && pos_eff <= 6'd27)
            begin
                acc_next = acc_eff | (32'(data_byte) << {pos_eff[1:0], 3'b000});
            end
        end
    end

    // Scale the timer clock by the prescaler
    always_comb
    begin
        if (presc_reg == whc_pkg::PRESCALE_256)
            scaled = clk_hz_reg >> 8;
        else
            scaled = clk_hz_reg >> presc_reg;
    end

    // One restoring division step: shift in a dividend bit, try subtract
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[QW-1]};
        fits      = (rem_shift >= {1'b0, acc_reg});
        rem_next  = fits ? 32'(rem_shift - {1'b0, acc_reg}) : rem_shift[31:0];
        quo_next  = {quo_reg[QW-2:0], fits};
        acc_zero  = (acc_reg == 32'd0);
    end

    // Hold parse state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 6'(whc_pkg::HEADER_BYTES);
            match_reg  <= 1'b1;
            acc_reg    <= 32'd0;
            clk_hz_reg <= QW'(40000000);
            presc_reg  <= 3'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            match_reg <= match_next;
            acc_reg   <= acc_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    whc_pkg::CFG_CLOCK_HZ: clk_hz_reg <= cfg_data[QW-1:0];
                    whc_pkg::CFG_PRESCALE: presc_reg  <= cfg_data[2:0];
                    default:               presc_reg  <= presc_reg;
                endcase
            end
        end
    end

    // Advance the divider and capture the result
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= 32'd0;
            quo_reg <= scaled;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end

        if (cmd.load)
        begin
            ok_out_reg     <= match_reg;
            zero_out_reg   <= acc_zero;
            period_out_reg <= acc_zero ? 32'hFFFF_FFFF : (32'(quo_reg) - 32'd1);
        end
    end

    assign header_ok    = ok_out_reg;
    assign timer_period = period_out_reg;
    assign rate_zero    = zero_out_reg;

endmodule

// ===== rtl/whc_ctrl.sv =====
// ----------------------------------------------------------------------------
// whc_ctrl
// Sequencer: take header bytes, run the serial divide, hand off the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module whc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  whc_pkg::whc_status_t status,
    output whc_pkg::whc_cmd_t    cmd
);

    localparam int CW = whc_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;

    // Decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && status.last_byte)
                begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(whc_pkg::DIV_STEPS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !out_ready) || cmd.load;
    end

    // Hold state, step count and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // The last header byte always starts a divide
    `WHC_ASSERT(a_last_starts_div, (in_valid && in_ready && status.last_byte) |=> (state_reg == ST_DIV), "last byte did not start divide")
    // A pending result is never overwritten
    `WHC_NEVER(a_no_overwrite, cmd.load && out_valid_reg && !out_ready, "result overwritten")
    // The step count stays within the divide length
    `WHC_ASSERT(a_cnt_range, (state_reg == ST_DIV) |-> (cnt_reg < CW'(whc_pkg::DIV_STEPS)), "divider step count out of range")
    // No byte is taken while the divider runs
    `WHC_NEVER(a_no_accept_busy, cmd.accept && (state_reg != ST_IDLE), "byte taken during divide")

endmodule

// ===== rtl/wav_header_check_rate_divider.sv =====
// ----------------------------------------------------------------------------
// wav_header_check_rate_divider
// WAV PCM header check and timer period from the sample rate.
//
//   channel  dir  beat                                    width
//   in_ch    in   data_byte, first_byte                   8 + 1
//   out_ch   out  header_ok, timer_period, rate_zero      1 + 32 + 1
//   cfg      in   cfg_we, cfg_index, cfg_data             1 + 1 + 28
//
// Header bytes are taken one per cycle while no divide is running. The final
// byte starts a serial restoring divide of one quotient bit per cycle; the
// result register is then loaded and the block takes new bytes again. Bytes
// after the header are taken and give nothing. Reset leaves the block waiting
// for a first byte. A result waiting on out_ch does not stop byte intake while
// idle, but the next result load waits for it and no bytes are taken meanwhile.
// ----------------------------------------------------------------------------
module wav_header_check_rate_divider
(
    input  logic                           clk,
    input  logic                           rst_n,
    whc_in_if.sink                         in_ch,
    whc_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [whc_pkg::CFG_DATA_W-1:0] cfg_data
);

    whc_pkg::whc_cmd_t    cmd;
    whc_pkg::whc_status_t status;

    // Sequencer
    whc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Parse, divide and result register
    whc_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .data_byte    (in_ch.data_byte),
        .first_byte   (in_ch.first_byte),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .header_ok    (out_ch.header_ok),
        .timer_period (out_ch.timer_period),
        .rate_zero    (out_ch.rate_zero)
    );

endmodule
